// File: src/igr_pkg.sv
package igr_pkg;

	localparam int AW = 24;
	localparam int MW = 34;
	localparam int VW = 26;
	localparam int RW = 34;
	localparam int FRAC = 28;
	localparam int GW = 23;
	localparam int PADDR_W = 5;

	localparam logic [2:0] REG_AXIS_SWAP = 3'd0;
	localparam logic [2:0] REG_NEGATE_X = 3'd1;
	localparam logic [2:0] REG_NEGATE_Y = 3'd2;
	localparam logic [2:0] REG_NEGATE_Z = 3'd3;
	localparam logic [2:0] REG_GRAVITY = 3'd4;

	localparam logic [GW-1:0] GRAVITY_RESET = 23'd160563;

	typedef logic signed [MW-1:0] mat_t [3][3];
	typedef logic signed [VW-1:0] vec_t [3];
	typedef logic signed [RW-1:0] res_t [3];

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [AW-1:0] accel_x;
		logic signed [AW-1:0] accel_y;
		logic signed [AW-1:0] accel_z;
	} req_word_t;

	typedef struct packed {
		logic signed [AW-1:0] nav_acc_x;
		logic signed [AW-1:0] nav_acc_y;
		logic signed [AW-1:0] nav_acc_z;
		logic signed [AW-1:0] body_lin_x;
		logic signed [AW-1:0] body_lin_y;
		logic signed [AW-1:0] body_lin_z;
		logic signed [AW-1:0] nav_lin_x;
		logic signed [AW-1:0] nav_lin_y;
		logic signed [AW-1:0] nav_lin_z;
	} rsp_word_t;

	typedef struct packed {
		logic en;
	} pipe_ctl_t;

	function automatic logic signed [AW-1:0] sat24(input logic signed [35:0] v);
		if (v > 36'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -36'sd8388608) begin
			return 24'sh800000;
		end
		return v[AW-1:0];
	endfunction

endpackage

// File: src/imu_gravity_removal_rotation.sv
// Throughput: one word per cycle; the whole pipeline holds while rsp is stalled.
// Stages: input remap, quaternion products, matrix, rotate products, round and
// gravity subtract, second rotate products, round, saturate into output register.
// arst_n clears stage valid bits and restores register defaults (gravity 160563).
module imu_gravity_removal_rotation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  igr_pkg::req_word_t          req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output igr_pkg::rsp_word_t          rsp_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [igr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	logic axis_swap_q, negate_x_q, negate_y_q, negate_z_q;
	logic [igr_pkg::GW-1:0] gravity_q;
	logic [2:0] reg_idx;
	logic [7:0] v_q;
	igr_pkg::pipe_ctl_t ctl;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_swap_q <= 1'b0;
			negate_x_q <= 1'b0;
			negate_y_q <= 1'b0;
			negate_z_q <= 1'b0;
			gravity_q <= igr_pkg::GRAVITY_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				igr_pkg::REG_AXIS_SWAP: axis_swap_q <= pwdata[0];
				igr_pkg::REG_NEGATE_X: negate_x_q <= pwdata[0];
				igr_pkg::REG_NEGATE_Y: negate_y_q <= pwdata[0];
				igr_pkg::REG_NEGATE_Z: negate_z_q <= pwdata[0];
				igr_pkg::REG_GRAVITY: gravity_q <= pwdata[igr_pkg::GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			igr_pkg::REG_AXIS_SWAP: prdata = {31'd0, axis_swap_q};
			igr_pkg::REG_NEGATE_X: prdata = {31'd0, negate_x_q};
			igr_pkg::REG_NEGATE_Y: prdata = {31'd0, negate_y_q};
			igr_pkg::REG_NEGATE_Z: prdata = {31'd0, negate_z_q};
			igr_pkg::REG_GRAVITY: prdata = {9'd0, gravity_q};
			default: prdata = 32'd0;
		endcase
	end

	assign ctl.en = !v_q[7] || rsp_ready;
	assign req_ready = ctl.en;
	assign rsp_valid = v_q[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ctl.en) begin
			v_q <= {v_q[6:0], req_valid};
		end
	end

	// stage 1: axis remap
	logic signed [24:0] sx, sy, sz, ax, ay, az;
	logic signed [15:0] qw_s1, qx_s1, qy_s1, qz_s1;
	igr_pkg::vec_t ab_s1, ab_s2, ab_s3, ab_s4;

	always_comb begin
		sx = 25'(req_data.accel_x);
		sy = 25'(req_data.accel_y);
		sz = 25'(req_data.accel_z);
		ax = axis_swap_q ? sy : sx;
		ay = axis_swap_q ? sx : sy;
		az = sz;
		if (negate_x_q) ax = -ax;
		if (negate_y_q) ay = -ay;
		if (negate_z_q) az = -az;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			qw_s1 <= req_data.quat_w;
			qx_s1 <= req_data.quat_x;
			qy_s1 <= req_data.quat_y;
			qz_s1 <= req_data.quat_z;
			ab_s1[0] <= igr_pkg::VW'(ax);
			ab_s1[1] <= igr_pkg::VW'(ay);
			ab_s1[2] <= igr_pkg::VW'(az);
			ab_s2 <= ab_s1;
			ab_s3 <= ab_s2;
			ab_s4 <= ab_s3;
		end
	end

	igr_pkg::mat_t m_s3, m_s4, m_s5;

	igr_matrix u_matrix (
		.clk(clk), .ctl(ctl),
		.qw(qw_s1), .qx(qx_s1), .qy(qy_s1), .qz(qz_s1),
		.m(m_s3)
	);

	// gravity in body frame: row 2 of R scaled by g
	logic signed [57:0] gprod_s4 [3];
	logic signed [57:0] gsum [3];
	igr_pkg::vec_t lin_s5, lin_s6, lin_s7;
	igr_pkg::res_t na_s5, na_s6, na_s7, nl_s7;
	logic signed [igr_pkg::AW-1:0] gb_sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gsum[i] = gprod_s4[i] + 58'(64'sd1 <<< (igr_pkg::FRAC - 1));
			gb_sat[i] = igr_pkg::sat24(36'($signed(gsum[i][57:igr_pkg::FRAC])));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++) begin
				gprod_s4[i] <= 58'(m_s3[2][i]) * 58'($signed({1'b0, gravity_q}));
				lin_s5[i] <= ab_s4[i] - igr_pkg::VW'(gb_sat[i]);
			end
			m_s4 <= m_s3;
			m_s5 <= m_s4;
			lin_s6 <= lin_s5;
			lin_s7 <= lin_s6;
			na_s6 <= na_s5;
			na_s7 <= na_s6;
		end
	end

	igr_rotate u_rot_acc (.clk(clk), .ctl(ctl), .m(m_s3), .v(ab_s3), .r(na_s5));
	igr_rotate u_rot_lin (.clk(clk), .ctl(ctl), .m(m_s5), .v(lin_s5), .r(nl_s7));

	igr_pkg::rsp_word_t out_s8;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			out_s8.nav_acc_x <= igr_pkg::sat24(36'(na_s7[0]));
			out_s8.nav_acc_y <= igr_pkg::sat24(36'(na_s7[1]));
			out_s8.nav_acc_z <= igr_pkg::sat24(36'(na_s7[2]));
			out_s8.body_lin_x <= igr_pkg::sat24(36'(lin_s7[0]));
			out_s8.body_lin_y <= igr_pkg::sat24(36'(lin_s7[1]));
			out_s8.body_lin_z <= igr_pkg::sat24(36'(lin_s7[2]));
			out_s8.nav_lin_x <= igr_pkg::sat24(36'(nl_s7[0]));
			out_s8.nav_lin_y <= igr_pkg::sat24(36'(nl_s7[1]));
			out_s8.nav_lin_z <= igr_pkg::sat24(36'(nl_s7[2]));
		end
	end

	assign rsp_data = out_s8;

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready)) else $error("ready mismatch");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> v_q[0]) else $error("word lost at entry");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled output changed");
endmodule

// File: src/igr_matrix.sv
module igr_matrix (
	input  logic                clk,
	input  igr_pkg::pipe_ctl_t  ctl,
	input  logic signed [15:0]  qw,
	input  logic signed [15:0]  qx,
	input  logic signed [15:0]  qy,
	input  logic signed [15:0]  qz,
	output igr_pkg::mat_t       m
);
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [igr_pkg::MW-1:0] one;
	logic signed [igr_pkg::MW-1:0] exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
	igr_pkg::mat_t m_s2;

	assign one = igr_pkg::MW'(64'sd1 <<< igr_pkg::FRAC);
	assign exx = igr_pkg::MW'(xx_s1);
	assign eyy = igr_pkg::MW'(yy_s1);
	assign ezz = igr_pkg::MW'(zz_s1);
	assign exy = igr_pkg::MW'(xy_s1);
	assign exz = igr_pkg::MW'(xz_s1);
	assign eyz = igr_pkg::MW'(yz_s1);
	assign ewx = igr_pkg::MW'(wx_s1);
	assign ewy = igr_pkg::MW'(wy_s1);
	assign ewz = igr_pkg::MW'(wz_s1);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			xy_s1 <= qx * qy;
			xz_s1 <= qx * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			wy_s1 <= qw * qy;
			wz_s1 <= qw * qz;
			m_s2[0][0] <= one - ((eyy + ezz) <<< 1);
			m_s2[0][1] <= (exy - ewz) <<< 1;
			m_s2[0][2] <= (exz + ewy) <<< 1;
			m_s2[1][0] <= (exy + ewz) <<< 1;
			m_s2[1][1] <= one - ((exx + ezz) <<< 1);
			m_s2[1][2] <= (eyz - ewx) <<< 1;
			m_s2[2][0] <= (exz - ewy) <<< 1;
			m_s2[2][1] <= (eyz + ewx) <<< 1;
			m_s2[2][2] <= one - ((exx + eyy) <<< 1);
		end
	end

	assign m = m_s2;
endmodule

// File: src/igr_rotate.sv
module igr_rotate (
	input  logic               clk,
	input  igr_pkg::pipe_ctl_t ctl,
	input  igr_pkg::mat_t      m,
	input  igr_pkg::vec_t      v,
	output igr_pkg::res_t      r
);
	localparam int PW = igr_pkg::MW + igr_pkg::VW;
	localparam int SW = PW + 2;

	logic signed [PW-1:0] prod_s1 [3][3];
	logic signed [SW-1:0] sum [3];
	igr_pkg::res_t res_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = SW'(prod_s1[i][0]) + SW'(prod_s1[i][1]) + SW'(prod_s1[i][2])
				+ SW'(64'sd1 <<< (igr_pkg::FRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= PW'(m[i][j]) * PW'(v[j]);
				end
				res_s2[i] <= igr_pkg::RW'(sum[i] >>> igr_pkg::FRAC);
			end
		end
	end

	assign r = res_s2;
endmodule
